[rtl/core/mse_pkg.sv]
package mse_pkg;

   // element width, fixed by the data format
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS,
      ST_MERGE,
      ST_DRAIN
   } mse_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic pass_setup;
      logic merge;
      logic drain;
   } mse_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic pass_end;
      logic sort_done;
      logic drain_end;
   } mse_stat_type;

endpackage

[rtl/core/mse_ram.sv]
module mse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

[rtl/core/mse_ctrl.sv]
module mse_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_last_in,
   input  mse_pkg::mse_stat_type stat,
   output mse_pkg::mse_cmd_type  cmd,
   output logic                  busy
);

   mse_pkg::mse_state_type state_ff;
   mse_pkg::mse_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mse_pkg::ST_IDLE: begin
            if (start && req_last_in) begin
               state_in = mse_pkg::ST_PASS;
            end
         end
         mse_pkg::ST_PASS: begin
            if (stat.sort_done) begin
               state_in = mse_pkg::ST_DRAIN;
            end else begin
               state_in = mse_pkg::ST_MERGE;
            end
         end
         mse_pkg::ST_MERGE: begin
            if (stat.pass_end) begin
               state_in = mse_pkg::ST_PASS;
            end
         end
         mse_pkg::ST_DRAIN: begin
            if (stat.drain_end) begin
               state_in = mse_pkg::ST_IDLE;
            end
         end
         default: state_in = mse_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         mse_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         mse_pkg::ST_PASS:  cmd.pass_setup = 1'b1;
         mse_pkg::ST_MERGE: cmd.merge      = 1'b1;
         mse_pkg::ST_DRAIN: cmd.drain      = 1'b1;
         default:           busy           = 1'b1;
      endcase
   end

endmodule

[rtl/core/mse_datapath.sv]
module mse_datapath #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mse_pkg::mse_cmd_type              cmd,
   output mse_pkg::mse_stat_type             stat,
   input  logic signed [mse_pkg::DATA_W-1:0] req_value,
   input  logic                              req_last_in,
   output logic                              rsp_strobe,
   output logic signed [mse_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                              rsp_last_out,
   output logic                              rsp_dropped
);

   localparam int DW = mse_pkg::DATA_W;
   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int WW = CW + 1;
   localparam int SW = CW + 2;

   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic [WW-1:0] width_ff, width_in;
   logic          src_ff, src_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] k_ff, k_in;
   logic          strobe_ff, strobe_in;
   logic          last_out_ff, last_out_in;
   logic          dropped_ff, dropped_in;

   logic [DW-1:0] pri_rd_a, pri_rd_b, scr_rd_a, scr_rd_b;
   logic [DW-1:0] rd_a, rd_b, chosen;
   logic          take_a, room, run_end;
   logic [SW-1:0] n_ext, w_ext, hi_ext;
   logic [SW-1:0] mid0, hi0, mid_r, hi_r, sum_m0, sum_h0, sum_mr, sum_hr;
   logic [CW-1:0] k_step;
   logic          pri_we, scr_we;
   logic [AW-1:0] pri_wa, rd_addr_a, rd_addr_b;
   logic [DW-1:0] pri_wd;

   assign n_ext  = {2'b00, count_ff};
   assign w_ext  = {1'b0, width_ff};
   assign hi_ext = {2'b00, hi_ff};

   // run bounds, clamped to the block length
   assign sum_m0 = w_ext;
   assign sum_h0 = w_ext << 1;
   assign sum_mr = hi_ext + w_ext;
   assign sum_hr = hi_ext + (w_ext << 1);
   assign mid0   = (sum_m0 < n_ext) ? sum_m0 : n_ext;
   assign hi0    = (sum_h0 < n_ext) ? sum_h0 : n_ext;
   assign mid_r  = (sum_mr < n_ext) ? sum_mr : n_ext;
   assign hi_r   = (sum_hr < n_ext) ? sum_hr : n_ext;

   assign rd_a   = src_ff ? scr_rd_a : pri_rd_a;
   assign rd_b   = src_ff ? scr_rd_b : pri_rd_b;
   assign take_a = (i_ff < mid_ff) && ((j_ff >= hi_ff) || ($signed(rd_a) <= $signed(rd_b)));
   assign chosen = take_a ? rd_a : rd_b;
   assign k_step = k_ff + CW'(1);
   assign run_end = (k_step == hi_ff);
   assign room   = (count_ff < CW'(MAX_ITEMS));

   assign stat.pass_end  = run_end && (hi_ff == count_ff);
   assign stat.sort_done = ({1'b0, width_ff} >= n_ext);
   assign stat.drain_end = (k_ff == count_ff - CW'(1));

   always_comb begin
      count_in    = count_ff;
      drop_in     = drop_ff;
      width_in    = width_ff;
      src_in      = src_ff;
      mid_in      = mid_ff;
      hi_in       = hi_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      strobe_in   = cmd.drain;
      last_out_in = cmd.drain && stat.drain_end;
      dropped_in  = drop_ff;
      if (cmd.load) begin
         if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            drop_in = 1'b1;
         end
         if (req_last_in) begin
            width_in = WW'(1);
            src_in   = 1'b0;
         end
      end else if (cmd.pass_setup) begin
         // first run pair of a pass, reads issued here
         mid_in = mid0[CW-1:0];
         hi_in  = hi0[CW-1:0];
         i_in   = '0;
         j_in   = mid0[CW-1:0];
         k_in   = '0;
      end else if (cmd.merge) begin
         k_in = k_step;
         if (take_a) begin
            i_in = i_ff + CW'(1);
         end else begin
            j_in = j_ff + CW'(1);
         end
         if (run_end) begin
            // move to the next run pair
            mid_in = mid_r[CW-1:0];
            hi_in  = hi_r[CW-1:0];
            i_in   = hi_ff;
            j_in   = mid_r[CW-1:0];
         end
         if (stat.pass_end) begin
            width_in = width_ff << 1;
            src_in   = ~src_ff;
         end
      end else if (cmd.drain) begin
         k_in = k_step;
         if (stat.drain_end) begin
            count_in = '0;
            drop_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         drop_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         drop_ff   <= drop_in;
         strobe_ff <= strobe_in;
      end
      width_ff    <= width_in;
      src_ff      <= src_in;
      mid_ff      <= mid_in;
      hi_ff       <= hi_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      last_out_ff <= last_out_in;
      dropped_ff  <= dropped_in;
   end

   // store ports
   assign pri_we    = (cmd.load && room) || (cmd.merge && src_ff);
   assign pri_wa    = cmd.load ? count_ff[AW-1:0] : k_ff[AW-1:0];
   assign pri_wd    = cmd.load ? req_value : chosen;
   assign scr_we    = cmd.merge && !src_ff;
   assign rd_addr_a = cmd.drain ? k_ff[AW-1:0] : i_in[AW-1:0];
   assign rd_addr_b = j_in[AW-1:0];

   mse_ram #(
      .WIDTH(DW),
      .DEPTH(MAX_ITEMS)
   ) u_primary (
      .clock    (clock),
      .wr_en    (pri_we),
      .wr_addr  (pri_wa),
      .wr_data  (pri_wd),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(pri_rd_a),
      .rd_data_b(pri_rd_b)
   );

   mse_ram #(
      .WIDTH(DW),
      .DEPTH(MAX_ITEMS)
   ) u_scratch (
      .clock    (clock),
      .wr_en    (scr_we),
      .wr_addr  (k_ff[AW-1:0]),
      .wr_data  (chosen),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(scr_rd_a),
      .rd_data_b(scr_rd_b)
   );

   assign rsp_strobe       = strobe_ff;
   assign rsp_sorted_value = rd_a;
   assign rsp_last_out     = last_out_ff;
   assign rsp_dropped      = dropped_ff;

endmodule

[rtl/core/merge_sort_engine.sv]
// merge_sort_engine: ascending sorter for blocks of signed 32-bit values
// input channel: a beat is taken on a clock edge with start high and busy low;
//   req_value is stored, req_last_in closes the block and starts the sort
// a block holds up to MAX_ITEMS values; beats past that are discarded and
//   rsp_dropped is set on every result of that block
// result channel: one beat per held value, in ascending order, each shown
//   for exactly one cycle with rsp_strobe; rsp_last_out marks the final beat
// the receiver cannot stall; results come out back to back, never held off
// sorting: a beat can be taken in every cycle with start high and busy low;
//   after the last beat the block goes through ceil(log2 n) merge passes, each
//   opened by a setup step, then merging one element per cycle through the
//   dual-read store; the block is then drained
// busy is high from the cycle after the last beat until the last result
//   has been read out; a new block may start in the cycle of the final strobe
// reset clears the controller, the fill count and the drop flag; the
//   stores need no clearing since only entries of the current block are read
module merge_sort_engine #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [mse_pkg::DATA_W-1:0] req_value,
   input  logic                              req_last_in,
   output logic                              rsp_strobe,
   output logic signed [mse_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                              rsp_last_out,
   output logic                              rsp_dropped
);

   mse_pkg::mse_cmd_type  cmd;
   mse_pkg::mse_stat_type stat;

   // sequencer: load, pass setup, merge, drain
   mse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_last_in(req_last_in),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   // stores, run counters and the compare unit
   mse_datapath #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_value       (req_value),
      .req_last_in     (req_last_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_last_out    (rsp_last_out),
      .rsp_dropped     (rsp_dropped)
   );

   // a result beat only follows a busy cycle
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a preceding busy cycle");

   // results of one block come out without gaps
   a_block_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_out) |=> rsp_strobe)
      else $error("gap inside a result block");

   // a merge pass never runs once the run width covers the block
   a_merge_needs_work: assert property (@(posedge clock) disable iff (reset)
      cmd.merge |-> !stat.sort_done)
      else $error("merge step with the block already sorted");

   // the last flag never appears without a strobe
   a_last_with_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_out |-> rsp_strobe)
      else $error("last flag without a result beat");

endmodule
